### rtl/fcp_pkg.sv
// ----------------------------------------------------------------------------
// fcp_pkg
// types, register indexes, axis codes and a shared saturation helper of the proxy block
// ----------------------------------------------------------------------------
`default_nettype none

package fcp_pkg;

    localparam int CFG_W    = 31;
    localparam int CFG_IDX_W = 3;
    localparam int MUL_W    = 34;
    localparam int MU_FRAC  = 14;

    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STATIC_MU  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KINETIC_MU = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEG_RADIUS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PEG_HEIGHT = 3'd4;

    localparam logic [CFG_W-1:0] STIFF_RESET = 31'd65536;

    localparam logic [1:0] AXIS_NONE = 2'd0;
    localparam logic [1:0] AXIS_X    = 2'd1;
    localparam logic [1:0] AXIS_Y    = 2'd2;
    localparam logic [1:0] AXIS_Z    = 2'd3;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic [1:0]         direction_hint;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] out_force_x;
        logic signed [31:0] out_force_y;
        logic signed [31:0] out_force_z;
        logic signed [31:0] proxy_out_x;
        logic signed [31:0] proxy_out_y;
        logic signed [31:0] proxy_out_z;
        logic [1:0]         contact_axis;
        logic               slipping;
    } result_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fff_ffff;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/fcp_mul.sv
// ----------------------------------------------------------------------------
// fcp_mul
// bit-serial shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_mul (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [fcp_pkg::MUL_W-1:0]      op_a,
    input  wire logic [fcp_pkg::MUL_W-1:0]      op_b,
    output logic                                done,
    output logic [2*fcp_pkg::MUL_W-1:0]         prod
);
    import fcp_pkg::*;

    localparam int CW = $clog2(MUL_W);

    logic [2*MUL_W-1:0] prod_reg;
    logic [MUL_W-1:0]   mcand_reg;
    logic [CW-1:0]      cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [MUL_W:0]     upper_next;

    always_comb
    begin
        upper_next = {1'b0, prod_reg[2*MUL_W-1:MUL_W]}
                   + (prod_reg[0] ? {1'b0, mcand_reg} : {(MUL_W+1){1'b0}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                prod_reg  <= {{MUL_W{1'b0}}, op_b};
                mcand_reg <= op_a;
                cnt_reg   <= '0;
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                prod_reg <= {upper_next, prod_reg[MUL_W-1:1]};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(MUL_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

`default_nettype wire

### rtl/fcp_sqrt.sv
// ----------------------------------------------------------------------------
// fcp_sqrt
// floor square root of a 64-bit value, one result bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] value,
    output logic             done,
    output logic [31:0]      root
);
    logic [63:0] rem_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= value;
                res_reg  <= '0;
                bit_reg  <= 64'h4000_0000_0000_0000;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg <= rem_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

`default_nettype wire

### rtl/fcp_div.sv
// ----------------------------------------------------------------------------
// fcp_div
// restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [63:0]      quotient
);
    logic [63:0] q_reg;
    logic [31:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] shifted;
    logic        ge;

    assign shifted = {rem_reg, q_reg[63]};
    assign ge      = shifted >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                q_reg    <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? 32'(shifted - {1'b0, dsr_reg}) : shifted[31:0];
                q_reg   <= {q_reg[62:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

### rtl/friction_cone_proxy.sv
// ----------------------------------------------------------------------------
// friction_cone_proxy
// stick/slip friction-cone proxy for haptic contact rendering
// ----------------------------------------------------------------------------
// One item at a time. An item without contact goes from ST_IDLE straight
// to ST_FIN and on to the result register. An item in contact runs a
// sequence on three bit-serial units: a 34-step shift-add multiplier, a
// 32-step square root and a 64-step divider. A sticking item uses five
// products and one root, a slipping item two more products and four
// divisions. The result register frees the input side: the next item is
// taken while a result still waits on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module friction_cone_proxy #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            sample_valid,
    output logic                                 sample_ready,
    input  wire fcp_pkg::sample_t                sample,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output fcp_pkg::result_t                     result,
    input  wire logic                            cfg_we,
    input  wire logic [fcp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fcp_pkg::CFG_W-1:0]       cfg_data
);
    import fcp_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SPA  = 4'd1;
    localparam logic [3:0] ST_SPB  = 4'd2;
    localparam logic [3:0] ST_SQA  = 4'd3;
    localparam logic [3:0] ST_SQB  = 4'd4;
    localparam logic [3:0] ST_ROOT = 4'd5;
    localparam logic [3:0] ST_LIM  = 4'd6;
    localparam logic [3:0] ST_CMA  = 4'd7;
    localparam logic [3:0] ST_CDA  = 4'd8;
    localparam logic [3:0] ST_DRA  = 4'd9;
    localparam logic [3:0] ST_CMB  = 4'd10;
    localparam logic [3:0] ST_CDB  = 4'd11;
    localparam logic [3:0] ST_DRB  = 4'd12;
    localparam logic [3:0] ST_FIN  = 4'd13;

    // configuration
    logic [CFG_W-1:0] stiffness_reg;
    logic [15:0]      static_mu_reg;
    logic [15:0]      kinetic_mu_reg;
    logic [CFG_W-1:0] peg_radius_reg;
    logic [CFG_W-1:0] peg_height_reg;

    // block state
    logic signed [31:0] proxy_a_reg;
    logic signed [31:0] proxy_b_reg;
    logic signed [31:0] proxy_n_reg;
    logic               was_contact_reg;
    logic               sticking_reg;

    // per-item registers
    logic [3:0]         state_reg;
    logic               busy_reg;
    logic [1:0]         axis_reg;
    logic signed [31:0] fx_reg;
    logic signed [31:0] fy_reg;
    logic signed [31:0] fz_reg;
    logic signed [31:0] a_reg;
    logic signed [31:0] b_reg;
    logic [31:0]        scalar_reg;
    logic [31:0]        mag_a_reg;
    logic [31:0]        mag_b_reg;
    logic               neg_a_reg;
    logic               neg_b_reg;
    logic signed [31:0] ta_reg;
    logic signed [31:0] tb_reg;
    logic [31:0]        diff_reg;
    logic [63:0]        sq_reg;
    logic [31:0]        norm_reg;
    logic [MUL_W-1:0]   limit_reg;
    logic               slip_reg;
    logic               out_valid_reg;
    result_t            out_data_reg;

    // sample decode
    logic [1:0]         axis_w;
    logic signed [31:0] a_w;
    logic signed [31:0] b_w;
    logic signed [31:0] n_w;
    logic signed [31:0] fn_w;
    logic               plus_w;
    logic [CFG_W-1:0]   off_w;
    logic signed [63:0] placed_w;

    logic [CFG_W-1:0]   k_w;
    logic signed [32:0] da_w;
    logic signed [32:0] db_w;
    logic [32:0]        dmag_w;
    logic               dneg_w;

    // units
    logic                   mul_start;
    logic [MUL_W-1:0]       mul_a;
    logic [MUL_W-1:0]       mul_b;
    logic                   mul_done;
    logic [2*MUL_W-1:0]     mul_prod;
    logic                   sqrt_start;
    logic                   sqrt_done;
    logic [31:0]            sqrt_root;
    logic                   div_start;
    logic [63:0]            div_dvd;
    logic [31:0]            div_dsr;
    logic                   div_done;
    logic [63:0]            div_q;

    // spring saturation
    logic [2*MUL_W-1:0] sp_shift;
    logic [31:0]        sp_p;
    logic [31:0]        sp_mag;
    logic signed [31:0] sp_val;
    logic [MUL_W-1:0]   lim_w;
    logic               slip_w;
    logic [31:0]        q_w;
    logic signed [63:0] drag_w;
    result_t            build_w;

    always_comb
    begin
        axis_w = AXIS_NONE;
        a_w    = sample.pos_x;
        b_w    = sample.pos_y;
        n_w    = sample.pos_z;
        fn_w   = sample.force_z;
        plus_w = sample.force_z > 0;
        off_w  = {1'b0, peg_height_reg[CFG_W-1:1]};
        if (sample.force_x != 0 || sample.direction_hint == AXIS_X)
        begin
            axis_w = AXIS_X;
            a_w    = sample.pos_y;
            b_w    = sample.pos_z;
            n_w    = sample.pos_x;
            fn_w   = sample.force_x;
            plus_w = sample.force_x > 0;
            off_w  = peg_radius_reg;
        end
        else if (sample.force_y != 0 || sample.direction_hint == AXIS_Y)
        begin
            axis_w = AXIS_Y;
            a_w    = sample.pos_x;
            b_w    = sample.pos_z;
            n_w    = sample.pos_y;
            fn_w   = sample.force_y;
            plus_w = sample.force_y < 0;
            off_w  = peg_radius_reg;
        end
        else if (sample.force_z != 0 || sample.direction_hint == AXIS_Z)
        begin
            axis_w = AXIS_Z;
        end
        placed_w = plus_w ? 64'(n_w) + $signed({33'd0, off_w})
                          : 64'(n_w) - $signed({33'd0, off_w});
    end

    assign k_w  = (stiffness_reg == '0) ? CFG_W'(1) : stiffness_reg;
    assign da_w = 33'(proxy_a_reg) - 33'(a_reg);
    assign db_w = 33'(proxy_b_reg) - 33'(b_reg);

    always_comb
    begin
        dneg_w = (state_reg == ST_SPA) ? da_w[32] : db_w[32];
        if (state_reg == ST_SPA)
            dmag_w = da_w[32] ? 33'(-da_w) : 33'(da_w);
        else
            dmag_w = db_w[32] ? 33'(-db_w) : 33'(db_w);
    end

    // operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SPA, ST_SPB:
            begin
                mul_a = MUL_W'(dmag_w);
                mul_b = MUL_W'(k_w);
            end
            ST_SQA:
            begin
                mul_a = MUL_W'(mag_a_reg);
                mul_b = MUL_W'(mag_a_reg);
            end
            ST_SQB:
            begin
                mul_a = MUL_W'(mag_b_reg);
                mul_b = MUL_W'(mag_b_reg);
            end
            ST_LIM:
            begin
                mul_a = MUL_W'(sticking_reg ? static_mu_reg : kinetic_mu_reg);
                mul_b = MUL_W'(scalar_reg);
            end
            ST_CMA:
            begin
                mul_a = MUL_W'(mag_a_reg);
                mul_b = limit_reg;
            end
            ST_CMB:
            begin
                mul_a = MUL_W'(mag_b_reg);
                mul_b = limit_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_CDA || state_reg == ST_CDB)
        begin
            div_dvd = mul_prod[63:0];
            div_dsr = norm_reg;
        end
        else
        begin
            div_dvd = 64'(diff_reg) << FRAC_BITS;
            div_dsr = {1'b0, k_w};
        end
    end

    assign mul_start  = !busy_reg && (state_reg inside {ST_SPA, ST_SPB, ST_SQA, ST_SQB,
                                                        ST_LIM, ST_CMA, ST_CMB});
    assign sqrt_start = !busy_reg && (state_reg == ST_ROOT);
    assign div_start  = !busy_reg && (state_reg inside {ST_CDA, ST_DRA, ST_CDB, ST_DRB});

    // spring force, clipped to 32-bit signed
    always_comb
    begin
        sp_shift = mul_prod >> FRAC_BITS;
        if ((|sp_shift[2*MUL_W-1:32]) || sp_shift[31:0] > 32'h8000_0000)
            sp_p = 32'h8000_0000;
        else
            sp_p = sp_shift[31:0];
        if (dneg_w)
            sp_mag = sp_p;
        else
            sp_mag = (sp_p == 32'h8000_0000) ? 32'h7fff_ffff : sp_p;
        sp_val = dneg_w ? -$signed(sp_mag) : $signed(sp_mag);
    end

    assign lim_w  = MUL_W'(mul_prod >> MU_FRAC);
    assign slip_w = {{(MUL_W-32){1'b0}}, norm_reg} > lim_w;
    assign q_w    = div_q[31:0];

    always_comb
    begin
        if (state_reg == ST_DRA)
            drag_w = neg_a_reg ? 64'(proxy_a_reg) + $signed(div_q)
                               : 64'(proxy_a_reg) - $signed(div_q);
        else
            drag_w = neg_b_reg ? 64'(proxy_b_reg) + $signed(div_q)
                               : 64'(proxy_b_reg) - $signed(div_q);
    end

    always_comb
    begin
        build_w = '0;
        build_w.contact_axis = axis_reg;
        build_w.slipping     = slip_reg;
        case (axis_reg)
            AXIS_X:
            begin
                build_w.out_force_x = fx_reg;
                build_w.out_force_y = ta_reg;
                build_w.out_force_z = tb_reg;
                build_w.proxy_out_x = proxy_n_reg;
                build_w.proxy_out_y = proxy_a_reg;
                build_w.proxy_out_z = proxy_b_reg;
            end
            AXIS_Y:
            begin
                build_w.out_force_x = ta_reg;
                build_w.out_force_y = fy_reg;
                build_w.out_force_z = tb_reg;
                build_w.proxy_out_x = proxy_a_reg;
                build_w.proxy_out_y = proxy_n_reg;
                build_w.proxy_out_z = proxy_b_reg;
            end
            AXIS_Z:
            begin
                build_w.out_force_x = ta_reg;
                build_w.out_force_y = tb_reg;
                build_w.out_force_z = fz_reg;
                build_w.proxy_out_x = proxy_a_reg;
                build_w.proxy_out_y = proxy_b_reg;
                build_w.proxy_out_z = proxy_n_reg;
            end
            default:
            begin
                build_w.out_force_x = fx_reg;
                build_w.out_force_y = fy_reg;
                build_w.out_force_z = fz_reg;
                build_w.slipping    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg   <= STIFF_RESET;
            static_mu_reg   <= '0;
            kinetic_mu_reg  <= '0;
            peg_radius_reg  <= '0;
            peg_height_reg  <= '0;
            proxy_a_reg     <= '0;
            proxy_b_reg     <= '0;
            proxy_n_reg     <= '0;
            was_contact_reg <= 1'b0;
            sticking_reg    <= 1'b1;
            state_reg       <= ST_IDLE;
            busy_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STIFFNESS:  stiffness_reg  <= cfg_data;
                    REG_STATIC_MU:  static_mu_reg  <= cfg_data[15:0];
                    REG_KINETIC_MU: kinetic_mu_reg <= cfg_data[15:0];
                    REG_PEG_RADIUS: peg_radius_reg <= cfg_data;
                    REG_PEG_HEIGHT: peg_height_reg <= cfg_data;
                    default:        ;
                endcase
            end

            if (mul_start || sqrt_start || div_start)
                busy_reg <= 1'b1;
            else if (mul_done || sqrt_done || div_done)
                busy_reg <= 1'b0;

            if (result_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (sample_valid)
                    begin
                        axis_reg   <= axis_w;
                        fx_reg     <= sample.force_x;
                        fy_reg     <= sample.force_y;
                        fz_reg     <= sample.force_z;
                        a_reg      <= a_w;
                        b_reg      <= b_w;
                        scalar_reg <= fn_w[31] ? 32'(-fn_w) : 32'(fn_w);
                        slip_reg   <= 1'b0;
                        if (axis_w == AXIS_NONE)
                        begin
                            was_contact_reg <= 1'b0;
                            state_reg       <= ST_FIN;
                        end
                        else
                        begin
                            if (!was_contact_reg)
                            begin
                                proxy_a_reg <= a_w;
                                proxy_b_reg <= b_w;
                                proxy_n_reg <= sat32(placed_w);
                            end
                            was_contact_reg <= fn_w != 0;
                            state_reg       <= ST_SPA;
                        end
                    end
                end
                ST_SPA:
                begin
                    if (mul_done)
                    begin
                        mag_a_reg <= sp_mag;
                        neg_a_reg <= dneg_w;
                        ta_reg    <= sp_val;
                        state_reg <= ST_SPB;
                    end
                end
                ST_SPB:
                begin
                    if (mul_done)
                    begin
                        mag_b_reg <= sp_mag;
                        neg_b_reg <= dneg_w;
                        tb_reg    <= sp_val;
                        state_reg <= ST_SQA;
                    end
                end
                ST_SQA:
                begin
                    if (mul_done)
                    begin
                        sq_reg    <= mul_prod[63:0];
                        state_reg <= ST_SQB;
                    end
                end
                ST_SQB:
                begin
                    if (mul_done)
                    begin
                        sq_reg    <= sq_reg + mul_prod[63:0];
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    if (sqrt_done)
                    begin
                        norm_reg  <= sqrt_root;
                        state_reg <= ST_LIM;
                    end
                end
                ST_LIM:
                begin
                    if (mul_done)
                    begin
                        limit_reg    <= lim_w;
                        slip_reg     <= slip_w;
                        sticking_reg <= !slip_w;
                        state_reg    <= slip_w ? ST_CMA : ST_FIN;
                    end
                end
                ST_CMA:
                begin
                    if (mul_done)
                        state_reg <= ST_CDA;
                end
                ST_CDA:
                begin
                    if (div_done)
                    begin
                        ta_reg    <= neg_a_reg ? -$signed(q_w) : $signed(q_w);
                        diff_reg  <= mag_a_reg - q_w;
                        state_reg <= ST_DRA;
                    end
                end
                ST_DRA:
                begin
                    if (div_done)
                    begin
                        proxy_a_reg <= sat32(drag_w);
                        state_reg   <= ST_CMB;
                    end
                end
                ST_CMB:
                begin
                    if (mul_done)
                        state_reg <= ST_CDB;
                end
                ST_CDB:
                begin
                    if (div_done)
                    begin
                        tb_reg    <= neg_b_reg ? -$signed(q_w) : $signed(q_w);
                        diff_reg  <= mag_b_reg - q_w;
                        state_reg <= ST_DRB;
                    end
                end
                ST_DRB:
                begin
                    if (div_done)
                    begin
                        proxy_b_reg <= sat32(drag_w);
                        state_reg   <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (!out_valid_reg || result_ready)
                    begin
                        out_data_reg  <= build_w;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    fcp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    fcp_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (sq_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    fcp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    assign sample_ready = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

`default_nettype wire
